// ===== sv/usp_pkg.sv =====
// ----------------------------------------------------------------------------
// usp_pkg
// Shared types and constants for the slicing plane generator.
// ----------------------------------------------------------------------------
package usp_pkg;

	localparam int MAX_PLANES_DEF = 64;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int UNIT_ONE       = 16384;

	// register indexes
	localparam logic [2:0] REG_AXIS_X   = 3'd0;
	localparam logic [2:0] REG_AXIS_Y   = 3'd1;
	localparam logic [2:0] REG_AXIS_Z   = 3'd2;
	localparam logic [2:0] REG_CENTER_X = 3'd3;
	localparam logic [2:0] REG_CENTER_Y = 3'd4;
	localparam logic [2:0] REG_CENTER_Z = 3'd5;
	localparam logic [2:0] REG_NUM_PL   = 3'd6;

	typedef struct packed {
		logic signed [31:0] vertex_x;
		logic signed [31:0] vertex_y;
		logic signed [31:0] vertex_z;
		logic               last_vertex;
	} vertex_t;

	typedef struct packed {
		logic        [6:0]  plane_index;
		logic signed [31:0] plane_distance;
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [31:0] origin_z;
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
		logic               last_plane;
	} plane_t;

	// saturate a signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [71:0] x);
		if (x > 72'sh0_0000_0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
		if (x < -72'sh0_0000_0000_8000_0000) return 32'sh8000_0000;
		return x[31:0];
	endfunction

endpackage

// ===== sv/usp_divider.sv =====
// ----------------------------------------------------------------------------
// usp_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module usp_divider #(
	parameter int W = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         go,
	input  logic [W-1:0] num,
	input  logic [W-1:0] den,
	output logic         done,
	output logic [W-1:0] quo
);
	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  rem_q, quo_q, den_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic [W:0]    trial;

	assign trial = {rem_q, quo_q[W-1]} - {1'b0, den_q};
	assign quo   = quo_q;

	// shift-subtract loop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CW'(W);
				rem_q <= '0;
				quo_q <= num;
				den_q <= den;
			end else if (run_q) begin
				if (!trial[W]) begin
					rem_q <= trial[W-1:0];
					quo_q <= {quo_q[W-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[W-2:0], quo_q[W-1]};
					quo_q <= {quo_q[W-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end
endmodule

// ===== sv/usp_sqrt.sv =====
// ----------------------------------------------------------------------------
// usp_sqrt
// Bitwise integer square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module usp_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [63:0] x,
	output logic        done,
	output logic [31:0] root
);
	logic [63:0] x_q, res_q, bit_q;
	logic        run_q;
	logic [63:0] rb;

	assign rb   = res_q + bit_q;
	assign root = res_q[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				x_q   <= x;
				res_q <= '0;
				bit_q <= 64'h4000_0000_0000_0000;
			end else if (run_q) begin
				if (x_q >= rb) begin
					x_q   <= x_q - rb;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
				if (bit_q == 64'd1) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end
endmodule

// ===== sv/uniform_slicing_plane_generator.sv =====
// ----------------------------------------------------------------------------
// uniform_slicing_plane_generator
// Normalizes an axis, tracks vertex projection extremes, emits slicing planes.
// ----------------------------------------------------------------------------
// Plain vertex: load, three products on one shared 33x17 multiplier, min/max
//   update; busy is high meanwhile.
// First vertex of a mesh adds the square root and the three unit-vector
//   divides, unless the axis is zero length and +Z is taken instead.
// Last vertex: per plane a divide, three multiplier steps and one strobe; the
//   receiver cannot stall. Reset loads the control and setting registers only.
module uniform_slicing_plane_generator #(
	parameter int MAX_PLANES = usp_pkg::MAX_PLANES_DEF,
	parameter int FRAC_BITS  = usp_pkg::FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [31:0]      cfg_data,
	input  logic             start,
	output logic             busy,
	input  usp_pkg::vertex_t vertex,
	output logic             result_valid,
	output usp_pkg::plane_t  result
);
	localparam logic [63:0] AXIS_MIN_SQ = 64'((128'd1 << (2 * FRAC_BITS)) / 128'd1000000000000);

	typedef enum logic [3:0] {
		S_IDLE, S_SS, S_SQ, S_DIV, S_MUL, S_ACC, S_PL_DIV, S_PL_MUL, S_EMIT
	} state_t;

	state_t state_q;
	logic signed [31:0] ax_q, ay_q, az_q, cx_q, cy_q, cz_q;
	logic [6:0] np_q;
	logic signed [15:0] ux_q, uy_q, uz_q;
	logic signed [31:0] pmin_q, pmax_q;
	logic mstart_q;
	usp_pkg::vertex_t v_q;
	logic [1:0] k_q;
	logic signed [63:0] acc_q;
	logic [63:0] ss_q;
	logic [31:0] mx_q, my_q, mz_q;
	logic [31:0] len_q;
	logic [6:0] n_q, i_q;
	logic signed [31:0] d_q;
	logic signed [31:0] o_q [3];
	logic dv_pending_q, sq_go_q;

	// shared multiplier: 33-bit signed by 17-bit signed
	logic signed [32:0] ma;
	logic signed [16:0] mb;
	logic signed [49:0] mp;
	assign mp = ma * mb;

	// divider and square root
	logic dv_go, dv_done, sq_go, sq_done;
	logic [63:0] dv_num, dv_den, dv_quo;
	logic [31:0] sq_root;
	usp_divider #(.W(64)) u_div (.clk, .arst_n, .go(dv_go), .num(dv_num),
		.den(dv_den), .done(dv_done), .quo(dv_quo));
	usp_sqrt u_sqrt (.clk, .arst_n, .go(sq_go), .x(ss_q), .done(sq_done), .root(sq_root));

	// helper selections
	logic [31:0] amx, amy, amz, mm, mcur;
	logic signed [31:0] acur;
	logic signed [15:0] ucur;
	logic [63:0] ssum;
	logic [5:0] lz;
	logic [32:0] total;
	logic [7:0] np1;
	logic [6:0] ncl;
	logic signed [33:0] diff2;
	logic signed [31:0] ccur;
	logic [63:0] q1;
	logic [15:0] qcl;
	logic signed [63:0] pr;
	logic signed [31:0] psat;

	always_comb begin
		amx = ax_q[31] ? 32'(-ax_q) : 32'(ax_q);
		amy = ay_q[31] ? 32'(-ay_q) : 32'(ay_q);
		amz = az_q[31] ? 32'(-az_q) : 32'(az_q);
		mm = mx_q;
		if (my_q > mm) mm = my_q;
		if (mz_q > mm) mm = mz_q;
		// left shift that brings the max magnitude up to bit 29
		lz = 6'd0;
		for (int b = 0; b < 32; b++) if (mm[b]) lz = (b < 29) ? 6'(29 - b) : 6'd0;
		ssum = 64'(mx_q) * 64'(mx_q) + 64'(my_q) * 64'(my_q) + 64'(mz_q) * 64'(mz_q);
		unique case (k_q)
			2'd0:    begin mcur = mx_q; acur = ax_q; ucur = ux_q; ccur = cx_q; end
			2'd1:    begin mcur = my_q; acur = ay_q; ucur = uy_q; ccur = cy_q; end
			default: begin mcur = mz_q; acur = az_q; ucur = uz_q; ccur = cz_q; end
		endcase
		total = 33'(signed'({pmax_q[31], pmax_q}) - signed'({pmin_q[31], pmin_q}));
		ncl = (np_q > 7'(MAX_PLANES)) ? 7'(MAX_PLANES) : np_q;
		np1 = {1'b0, n_q} + 8'd1;
		diff2 = 34'(2 * 34'(d_q)) - (34'(pmin_q) + 34'(pmax_q));
		q1 = (dv_quo + 64'd1) >> 1;
		qcl = (q1 > 64'(usp_pkg::UNIT_ONE)) ? 16'(usp_pkg::UNIT_ONE) : q1[15:0];
		pr = (acc_q + 64'sd8192) >>> 14;
		psat = usp_pkg::sat32(72'(pr));
		ma = '0; mb = '0;
		if (state_q == S_MUL) begin
			unique case (k_q)
				2'd0:    ma = 33'(v_q.vertex_x);
				2'd1:    ma = 33'(v_q.vertex_y);
				default: ma = 33'(v_q.vertex_z);
			endcase
			mb = 17'(ucur);
		end else if (state_q == S_PL_MUL) begin
			ma = 33'(diff2);
			mb = 17'(ucur);
		end
		if (state_q == S_DIV || state_q == S_SQ) begin
			dv_num = {17'd0, mcur, 15'd0};
			dv_den = {32'd0, len_q};
		end else begin
			dv_num = 64'(total) * 64'(i_q) + 64'(np1 >> 1);
			dv_den = 64'(np1);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ax_q <= '0; ay_q <= '0; az_q <= 32'sd65536;
			cx_q <= '0; cy_q <= '0; cz_q <= '0;
			np_q <= 7'd1;
			ux_q <= '0; uy_q <= '0; uz_q <= 16'sd16384;
			pmin_q <= 32'sh7FFF_FFFF; pmax_q <= 32'sh8000_0000;
			mstart_q <= 1'b1;
			k_q <= '0;
			result_valid <= 1'b0;
			busy <= 1'b0;
			dv_pending_q <= 1'b0;
			sq_go_q <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			dv_pending_q <= 1'b0;
			sq_go_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					usp_pkg::REG_AXIS_X:   ax_q <= cfg_data;
					usp_pkg::REG_AXIS_Y:   ay_q <= cfg_data;
					usp_pkg::REG_AXIS_Z:   az_q <= cfg_data;
					usp_pkg::REG_CENTER_X: cx_q <= cfg_data;
					usp_pkg::REG_CENTER_Y: cy_q <= cfg_data;
					usp_pkg::REG_CENTER_Z: cz_q <= cfg_data;
					usp_pkg::REG_NUM_PL:   np_q <= cfg_data[6:0];
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: if (start) begin
					v_q <= vertex;
					busy <= 1'b1;
					k_q <= '0;
					acc_q <= '0;
					mx_q <= amx; my_q <= amy; mz_q <= amz;
					state_q <= mstart_q ? S_SS : S_MUL;
				end
				S_SS: begin
					pmin_q <= 32'sh7FFF_FFFF; pmax_q <= 32'sh8000_0000;
					mstart_q <= 1'b0;
					if (ssum <= AXIS_MIN_SQ) begin
						ux_q <= '0; uy_q <= '0; uz_q <= 16'sd16384;
						state_q <= S_MUL;
					end else begin
						mx_q <= mx_q << lz; my_q <= my_q << lz; mz_q <= mz_q << lz;
						ss_q <= ssum << (2 * lz);
						sq_go_q <= 1'b1;
						state_q <= S_SQ;
					end
				end
				S_SQ: if (sq_done) begin
					len_q <= sq_root;
					dv_pending_q <= 1'b1;
					state_q <= S_DIV;
				end
				S_DIV: if (dv_done) begin
					unique case (k_q)
						2'd0:    ux_q <= acur[31] ? -16'(qcl) : 16'(qcl);
						2'd1:    uy_q <= acur[31] ? -16'(qcl) : 16'(qcl);
						default: uz_q <= acur[31] ? -16'(qcl) : 16'(qcl);
					endcase
					if (k_q == 2'd2) begin
						k_q <= '0;
						state_q <= S_MUL;
					end else begin
						k_q <= k_q + 2'd1;
						dv_pending_q <= 1'b1;
					end
				end
				S_MUL: begin
					acc_q <= acc_q + 64'(mp);
					if (k_q == 2'd2) state_q <= S_ACC;
					else k_q <= k_q + 2'd1;
				end
				S_ACC: begin
					if (psat < pmin_q) pmin_q <= psat;
					if (psat > pmax_q) pmax_q <= psat;
					if (!v_q.last_vertex) begin
						busy <= 1'b0;
						state_q <= S_IDLE;
					end else begin
						mstart_q <= 1'b1;
						n_q <= ncl;
						i_q <= 7'd1;
						if (ncl == 7'd0) begin
							busy <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							dv_pending_q <= 1'b1;
							state_q <= S_PL_DIV;
						end
					end
				end
				S_PL_DIV: if (dv_done) begin
					d_q <= 32'(pmin_q + 32'(dv_quo));
					k_q <= '0;
					state_q <= S_PL_MUL;
				end
				S_PL_MUL: begin
					o_q[k_q] <= usp_pkg::sat32(72'(ccur) +
						72'((64'(mp) + 64'sd16384) >>> 15));
					if (k_q == 2'd2) state_q <= S_EMIT;
					else k_q <= k_q + 2'd1;
				end
				S_EMIT: begin
					result_valid <= 1'b1;
					result.plane_index <= i_q;
					result.plane_distance <= d_q;
					result.origin_x <= o_q[0];
					result.origin_y <= o_q[1];
					result.origin_z <= o_q[2];
					result.normal_x <= ux_q;
					result.normal_y <= uy_q;
					result.normal_z <= uz_q;
					result.last_plane <= (i_q == n_q);
					if (i_q == n_q) begin
						busy <= 1'b0;
						state_q <= S_IDLE;
					end else begin
						i_q <= i_q + 7'd1;
						dv_pending_q <= 1'b1;
						state_q <= S_PL_DIV;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// one-cycle launch pulses for the divider and the square root
	assign sq_go = sq_go_q;
	assign dv_go = dv_pending_q;
endmodule

// ===== sv/usp_checker.sv =====
// ----------------------------------------------------------------------------
// usp_checker
// Port-level checks on the plane generator, bound to the top level.
// ----------------------------------------------------------------------------
module usp_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            start,
	input logic            busy,
	input logic            result_valid,
	input usp_pkg::plane_t result
);
	// a beat goes out only while a mesh is being finished
	a_res_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy)) else $error("result without busy");
	// plane index is never zero
	a_idx: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.plane_index != 7'd0) else $error("zero plane index");
	// accepted item makes the block busy
	a_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("not busy after accept");
endmodule

bind uniform_slicing_plane_generator usp_checker u_usp_checker (
	.clk, .arst_n, .start, .busy, .result_valid, .result
);

// ===== sim/usp_plane_checker.sv =====
// ----------------------------------------------------------------------------
// usp_plane_checker
// Watches the vertex and plane channels of the slicing plane generator,
// predicts every plane from the accepted vertices and register writes, and
// compares each plane beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module usp_plane_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [31:0]      cfg_data,
	input  logic             start,
	input  logic             busy,
	input  usp_pkg::vertex_t vertex,
	input  logic             result_valid,
	input  usp_pkg::plane_t  result,
	output int               fail_count,
	output int               pending_planes,
	output int               planes_seen
);
	// shadow registers and predictor state
	logic signed [31:0] axis_x, axis_y, axis_z;
	logic signed [31:0] ctr_x, ctr_y, ctr_z;
	logic [6:0]         plane_req;
	logic signed [15:0] unit_x, unit_y, unit_z;
	logic signed [63:0] proj_min, proj_max;
	logic               new_mesh;
	usp_pkg::plane_t    planes_due[$];

	function automatic logic signed [63:0] clip32(input logic signed [63:0] x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	function automatic logic [63:0] root64(input logic [63:0] x);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic signed [15:0] unit_of(input logic signed [31:0] a,
			input logic [63:0] m, input logic [63:0] len);
		logic [63:0] q;
		q = ((m << 15) / len + 1) >> 1;
		if (q > usp_pkg::UNIT_ONE) q = 64'(usp_pkg::UNIT_ONE);
		return a[31] ? -$signed(q[15:0]) : $signed(q[15:0]);
	endfunction

	// normalize the axis into the unit vector, +Z when it is zero length
	task automatic normalize_axis();
		logic [63:0] mx, my, mz, mm, len;
		mx = axis_x[31] ? 64'(-64'(axis_x)) : 64'(axis_x);
		my = axis_y[31] ? 64'(-64'(axis_y)) : 64'(axis_y);
		mz = axis_z[31] ? 64'(-64'(axis_z)) : 64'(axis_z);
		if (mx * mx + my * my + mz * mz == 0) begin
			unit_x = 0;
			unit_y = 0;
			unit_z = 16'(usp_pkg::UNIT_ONE);
		end else begin
			mm = mx;
			if (my > mm) mm = my;
			if (mz > mm) mm = mz;
			while (mm < (64'd1 << 29)) begin
				mx = mx << 1;
				my = my << 1;
				mz = mz << 1;
				mm = mm << 1;
			end
			len = root64(mx * mx + my * my + mz * mz);
			unit_x = unit_of(axis_x, mx, len);
			unit_y = unit_of(axis_y, my, len);
			unit_z = unit_of(axis_z, mz, len);
		end
	endtask

	// project one vertex; on the last one queue the planes
	task automatic take_vertex(input usp_pkg::vertex_t v);
		logic signed [63:0] p, span, mid2, d, diff2;
		logic [63:0] n, i;
		usp_pkg::plane_t pl;
		if (new_mesh) begin
			normalize_axis();
			proj_min = 64'sd2147483647;
			proj_max = -64'sd2147483648;
			new_mesh = 0;
		end
		p = 64'(v.vertex_x) * unit_x + 64'(v.vertex_y) * unit_y
			+ 64'(v.vertex_z) * unit_z;
		p = clip32((p + 8192) >>> 14);
		if (p < proj_min) proj_min = p;
		if (p > proj_max) proj_max = p;
		if (v.last_vertex) begin
			new_mesh = 1;
			n = (plane_req > 64) ? 64 : plane_req;
			span = proj_max - proj_min;
			mid2 = proj_min + proj_max;
			for (i = 1; i <= n; i++) begin
				d = proj_min + 64'((64'(span) * i + (n + 1) / 2) / (n + 1));
				diff2 = 2 * d - mid2;
				pl.plane_index = i[6:0];
				pl.plane_distance = d[31:0];
				pl.origin_x = clip32(64'(ctr_x) + ((unit_x * diff2 + 16384) >>> 15));
				pl.origin_y = clip32(64'(ctr_y) + ((unit_y * diff2 + 16384) >>> 15));
				pl.origin_z = clip32(64'(ctr_z) + ((unit_z * diff2 + 16384) >>> 15));
				pl.normal_x = unit_x;
				pl.normal_y = unit_y;
				pl.normal_z = unit_z;
				pl.last_plane = (i == n);
				planes_due.insert(planes_due.size(), pl);
			end
		end
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("MISMATCH plane %0d: %s got %0h want %0h", planes_seen, what, got, want);
		fail_count++;
	endtask

	task automatic check_plane(input usp_pkg::plane_t got);
		usp_pkg::plane_t want;
		if (planes_due.size() == 0) begin
			report_mismatch("unexpected beat", 0, 0);
			return;
		end
		want = planes_due.pop_front();
		if (got.plane_index != want.plane_index)
			report_mismatch("plane_index", got.plane_index, want.plane_index);
		if (got.plane_distance != want.plane_distance)
			report_mismatch("plane_distance", got.plane_distance, want.plane_distance);
		if (got.origin_x != want.origin_x)
			report_mismatch("origin_x", got.origin_x, want.origin_x);
		if (got.origin_y != want.origin_y)
			report_mismatch("origin_y", got.origin_y, want.origin_y);
		if (got.origin_z != want.origin_z)
			report_mismatch("origin_z", got.origin_z, want.origin_z);
		if (got.normal_x != want.normal_x)
			report_mismatch("normal_x", got.normal_x, want.normal_x);
		if (got.normal_y != want.normal_y)
			report_mismatch("normal_y", got.normal_y, want.normal_y);
		if (got.normal_z != want.normal_z)
			report_mismatch("normal_z", got.normal_z, want.normal_z);
		if (got.last_plane != want.last_plane)
			report_mismatch("last_plane", got.last_plane, want.last_plane);
	endtask

	// sample both channels at the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_x = 0; axis_y = 0; axis_z = 32'sd65536;
			ctr_x = 0; ctr_y = 0; ctr_z = 0;
			plane_req = 1;
			unit_x = 0; unit_y = 0; unit_z = 16'(usp_pkg::UNIT_ONE);
			proj_min = 64'sd2147483647;
			proj_max = -64'sd2147483648;
			new_mesh = 1;
			planes_due.delete();
			fail_count = 0;
			planes_seen = 0;
		end else begin
			if (result_valid) begin
				check_plane(result);
				planes_seen++;
			end
			if (cfg_we) begin
				case (cfg_index)
					usp_pkg::REG_AXIS_X:   axis_x = cfg_data;
					usp_pkg::REG_AXIS_Y:   axis_y = cfg_data;
					usp_pkg::REG_AXIS_Z:   axis_z = cfg_data;
					usp_pkg::REG_CENTER_X: ctr_x = cfg_data;
					usp_pkg::REG_CENTER_Y: ctr_y = cfg_data;
					usp_pkg::REG_CENTER_Z: ctr_z = cfg_data;
					usp_pkg::REG_NUM_PL:   plane_req = cfg_data[6:0];
					default: ;
				endcase
			end
			if (start && !busy) take_vertex(vertex);
		end
		pending_planes = planes_due.size();
	end
endmodule

// ===== sim/uniform_slicing_plane_generator_tb.sv =====
// ----------------------------------------------------------------------------
// uniform_slicing_plane_generator_tb
// Drives meshes of vertices and register settings into the slicing plane
// generator under varying idle patterns; the checker predicts and compares.
// ----------------------------------------------------------------------------
module uniform_slicing_plane_generator_tb;
	localparam int CYCLE_LIMIT = 6000000;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [2:0]       cfg_index;
	logic [31:0]      cfg_data;
	logic             start;
	logic             busy;
	usp_pkg::vertex_t vertex;
	logic             result_valid;
	usp_pkg::plane_t  result;
	int               fail_count, pending_planes, planes_seen;
	int               cycles;
	int               vertices_sent, meshes_sent;
	int               gap_pct;

	uniform_slicing_plane_generator uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .start(start), .busy(busy), .vertex(vertex),
		.result_valid(result_valid), .result(result)
	);

	usp_plane_checker chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .start(start), .busy(busy), .vertex(vertex),
		.result_valid(result_valid), .result(result), .fail_count(fail_count),
		.pending_planes(pending_planes), .planes_seen(planes_seen)
	);

	always begin
		clk = 0;
		#1;
		clk = 1;
		#1;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 0;
	endtask

	// wait for every predicted plane, then the worst-case tail of a mesh
	task automatic drain();
		@(negedge clk);
		while (pending_planes != 0 || busy) @(negedge clk);
		repeat (600) @(negedge clk);
	endtask

	task automatic vertex_sent_inc(input logic last);
		vertices_sent++;
		if (last) meshes_sent++;
	endtask

	// one vertex beat, raised once the block is free so the next edge takes it
	task automatic send_vertex(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z, input logic last);
		@(negedge clk);
		while ($urandom_range(99) < gap_pct) @(negedge clk);
		while (busy) @(negedge clk);
		start = 1;
		vertex = '{x, y, z, last};
		@(negedge clk);
		start = 0;
		vertex_sent_inc(last);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom;
			default: return $signed($urandom_range(2000000)) - 1000000;
		endcase
	endfunction

	function automatic logic [31:0] rand_axis();
		case ($urandom_range(6))
			0: return 32'd0;
			1: return 32'h7FFF_FFFF;
			2: return 32'h8000_0000;
			3: return $urandom;
			4: return $signed($urandom_range(32)) - 16;
			default: return $signed($urandom_range(262144)) - 131072;
		endcase
	endfunction

	task automatic random_mesh(input int len);
		for (int k = 0; k < len; k++)
			send_vertex(rand_coord(), rand_coord(), rand_coord(), k == len - 1);
	endtask

	initial begin
		cycles = 0;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = usp_pkg::REG_AXIS_X;
		cfg_data = 0;
		start = 0;
		vertex = '0;
		vertices_sent = 0;
		meshes_sent = 0;
		gap_pct = 0;
		repeat (4) @(negedge clk);
		arst_n = 1;

		// directed: reset settings, extremes, single-vertex mesh
		send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
		send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
		send_vertex(32'h0001_0000, 32'd0, 32'hFFFF_0000, 1'b1);
		drain();
		// zero-length axis falls back to +Z; extreme centers; max planes
		write_reg(usp_pkg::REG_AXIS_Z, 32'd0);
		write_reg(usp_pkg::REG_CENTER_X, 32'h7FFF_FFFF);
		write_reg(usp_pkg::REG_CENTER_Y, 32'h8000_0000);
		write_reg(usp_pkg::REG_CENTER_Z, 32'h7FFF_0000);
		write_reg(usp_pkg::REG_NUM_PL, 32'd64);
		send_vertex(32'd0, 32'd0, 32'h8000_0000, 1'b0);
		send_vertex(32'd0, 32'd0, 32'h7FFF_FFFF, 1'b1);
		drain();
		// above the plane limit, diagonal extreme axis
		write_reg(usp_pkg::REG_NUM_PL, 32'd127);
		write_reg(usp_pkg::REG_AXIS_X, 32'h8000_0000);
		write_reg(usp_pkg::REG_AXIS_Y, 32'h7FFF_FFFF);
		write_reg(usp_pkg::REG_AXIS_Z, 32'h8000_0000);
		send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
		send_vertex(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
		drain();
		// zero planes: mesh ends silently; tiny axis
		write_reg(usp_pkg::REG_NUM_PL, 32'd0);
		write_reg(usp_pkg::REG_AXIS_X, 32'd1);
		write_reg(usp_pkg::REG_AXIS_Y, 32'd0);
		write_reg(usp_pkg::REG_AXIS_Z, 32'd0);
		send_vertex(32'h0010_0000, 32'd5, 32'd7, 1'b0);
		send_vertex(32'hFFF0_0000, 32'd9, 32'd3, 1'b1);
		drain();
		write_reg(usp_pkg::REG_NUM_PL, 32'd3);
		write_reg(usp_pkg::REG_CENTER_X, 32'd0);
		write_reg(usp_pkg::REG_CENTER_Y, 32'd0);
		write_reg(usp_pkg::REG_CENTER_Z, 32'd0);
		write_reg(usp_pkg::REG_AXIS_Y, 32'hFFFF_FFFF);
		random_mesh(4);
		drain();

		// random phases: sender idle 23%, then 54%, then none
		for (int ph = 0; ph < 3; ph++) begin
			gap_pct = (ph == 0) ? 23 : (ph == 1) ? 54 : 0;
			while (vertices_sent < 10 + (ph + 1) * 83) begin
				if ($urandom_range(3) == 0) begin
					drain();
					write_reg(usp_pkg::REG_AXIS_X, rand_axis());
					write_reg(usp_pkg::REG_AXIS_Y, rand_axis());
					write_reg(usp_pkg::REG_AXIS_Z, rand_axis());
					write_reg(usp_pkg::REG_CENTER_X, rand_coord());
					write_reg(usp_pkg::REG_CENTER_Y, rand_coord());
					write_reg(usp_pkg::REG_CENTER_Z, rand_coord());
					write_reg(usp_pkg::REG_NUM_PL, ($urandom_range(9) == 0) ?
						$urandom_range(127) : $urandom_range(1, 6));
				end
				random_mesh($urandom_range(1, 6));
			end
		end

		drain();
		$display("Covered %0d vertices in %0d meshes, %0d planes checked.",
			vertices_sent, meshes_sent, planes_seen);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule
